### src/mvrm_pkg.sv
package mvrm_pkg;

  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned DOT_W     = 64;
  localparam int unsigned ROW_W     = 16;
  localparam int unsigned COL_CNT_W = 7;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = 2;
  localparam int unsigned QUEUE_CNT_W = 3;

  typedef enum logic {
    REQ_VECTOR = 1'b0,
    REQ_MATRIX = 1'b1
  } req_type_e;

  // register select is paddr[2]
  typedef enum logic {
    REG_COL_COUNT = 1'b0,
    REG_ROW_COUNT = 1'b1
  } reg_index_e;

  typedef struct packed {
    logic [COL_CNT_W-1:0] col_count;
    logic [ROW_W-1:0]     row_count;
  } cfg_t;

  // one matrix element with its vector operand, ready for the datapath
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic signed [VALUE_W-1:0] vec;
    logic                      first_col;
    logic                      last_col;
    logic [ROW_W-1:0]          row_number;
    logic                      last_row;
  } item_t;

endpackage

### src/mvrm_req_if.sv
interface mvrm_req_if;
  logic                               valid;
  logic                               ready;
  logic                               req_type;
  logic signed [mvrm_pkg::VALUE_W-1:0] value;

  modport source (output valid, req_type, value, input ready);
  modport sink (input valid, req_type, value, output ready);
endinterface

### src/mvrm_res_if.sv
interface mvrm_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [mvrm_pkg::DOT_W-1:0]   dot_product;
  logic signed [mvrm_pkg::VALUE_W-1:0] row_max;
  logic [mvrm_pkg::ROW_W-1:0]          row_number;
  logic                                last_row;

  modport source (output valid, dot_product, row_max, row_number, last_row, input ready);
  modport sink (input valid, dot_product, row_max, row_number, last_row, output ready);
endinterface

### src/mvrm_cfg.sv
module mvrm_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mvrm_pkg::PADDR_W-1:0]        paddr,
  input  logic [mvrm_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [mvrm_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output mvrm_pkg::cfg_t                      cfg_o
);

  logic [mvrm_pkg::COL_CNT_W-1:0] col_count_q, col_count_d;
  logic [mvrm_pkg::ROW_W-1:0]     row_count_q, row_count_d;
  logic                           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    col_count_d = col_count_q;
    row_count_d = row_count_q;
    if (wr_en) begin
      if (paddr[2] == mvrm_pkg::REG_COL_COUNT) begin
        col_count_d = pwdata[mvrm_pkg::COL_CNT_W-1:0];
      end else begin
        row_count_d = pwdata[mvrm_pkg::ROW_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_count_q <= mvrm_pkg::COL_CNT_W'(1);
      row_count_q <= mvrm_pkg::ROW_W'(1);
    end else begin
      col_count_q <= col_count_d;
      row_count_q <= row_count_d;
    end
  end

  always_comb begin
    if (paddr[2] == mvrm_pkg::REG_COL_COUNT) begin
      prdata = mvrm_pkg::APB_DATA_W'(col_count_q);
    end else begin
      prdata = mvrm_pkg::APB_DATA_W'(row_count_q);
    end
  end

  assign cfg_o.col_count = col_count_q;
  assign cfg_o.row_count = row_count_q;

endmodule

### src/mvrm_front.sv
module mvrm_front #(
  parameter int unsigned MAX_COLS    = 64,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mvrm_pkg::cfg_t   cfg_i,
  mvrm_req_if.sink         req_i,
  input  logic             full_i,
  output logic             push_o,
  output mvrm_pkg::item_t  item_o
);

  localparam int unsigned AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned CW = $clog2(MAX_COLS + 1);
  localparam int unsigned EW = (CW > mvrm_pkg::COL_CNT_W) ? CW : mvrm_pkg::COL_CNT_W;
  localparam int unsigned RW = mvrm_pkg::ROW_W;

  logic [VALUE_WIDTH-1:0] vec_mem [MAX_COLS];

  logic [AW-1:0] fill_q, fill_d;
  logic [AW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;

  logic          s1_valid_q, s1_valid_d;
  logic signed [mvrm_pkg::VALUE_W-1:0] s1_value_q;
  logic          s1_first_q, s1_last_col_q, s1_last_row_q;
  logic [RW-1:0] s1_row_q;
  logic [VALUE_WIDTH-1:0] s1_vec_q;

  logic          accept, is_matrix;
  logic [EW-1:0] cols_eff, fill_ext, col_ext, fidx, cidx;
  logic          fill_wrap, last_col;
  logic [RW-1:0] rows_eff, ridx;
  logic          last_row;
  logic signed [mvrm_pkg::VALUE_W-1:0] value_ext;

  assign req_i.ready = !s1_valid_q || !full_i;
  assign accept      = req_i.valid && req_i.ready;
  assign is_matrix   = (req_i.req_type == mvrm_pkg::REQ_MATRIX);

  // only the low bits carry the element
  assign value_ext = mvrm_pkg::VALUE_W'($signed(req_i.value[VALUE_WIDTH-1:0]));

  always_comb begin
    if (cfg_i.col_count == '0) begin
      cols_eff = EW'(1);
    end else if (EW'(cfg_i.col_count) > EW'(MAX_COLS)) begin
      cols_eff = EW'(MAX_COLS);
    end else begin
      cols_eff = EW'(cfg_i.col_count);
    end
    rows_eff = (cfg_i.row_count == '0) ? RW'(1) : cfg_i.row_count;
  end

  // positions past the end after a register change count as the last one
  always_comb begin
    fill_ext  = EW'(fill_q);
    col_ext   = EW'(col_q);
    fidx      = (fill_ext >= cols_eff) ? cols_eff - EW'(1) : fill_ext;
    cidx      = (col_ext >= cols_eff) ? cols_eff - EW'(1) : col_ext;
    fill_wrap = ({1'b0, fidx} + (EW+1)'(1)) >= {1'b0, cols_eff};
    last_col  = ({1'b0, cidx} + (EW+1)'(1)) >= {1'b0, cols_eff};
    ridx      = (row_q >= rows_eff) ? rows_eff - RW'(1) : row_q;
    last_row  = ({1'b0, ridx} + (RW+1)'(1)) >= {1'b0, rows_eff};
  end

  always_comb begin
    fill_d = fill_q;
    col_d  = col_q;
    row_d  = row_q;
    if (accept) begin
      if (!is_matrix) begin
        fill_d = fill_wrap ? '0 : fidx[AW-1:0] + AW'(1);
      end else if (!last_col) begin
        col_d = cidx[AW-1:0] + AW'(1);
      end else begin
        col_d = '0;
        row_d = last_row ? '0 : ridx + RW'(1);
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_valid_q && !full_i) begin
      s1_valid_d = 1'b0;
    end
    if (accept && is_matrix) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      fill_q     <= fill_d;
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  // vector store, registered read for matrix elements
  always_ff @(posedge clk_i) begin
    if (accept && !is_matrix) begin
      vec_mem[fidx[AW-1:0]] <= req_i.value[VALUE_WIDTH-1:0];
    end
    if (accept && is_matrix) begin
      s1_vec_q      <= vec_mem[cidx[AW-1:0]];
      s1_value_q    <= value_ext;
      s1_first_q    <= (cidx == '0);
      s1_last_col_q <= last_col;
      s1_row_q      <= ridx;
      s1_last_row_q <= last_row;
    end
  end

  assign push_o            = s1_valid_q && !full_i;
  assign item_o.value      = s1_value_q;
  assign item_o.vec        = mvrm_pkg::VALUE_W'($signed(s1_vec_q));
  assign item_o.first_col  = s1_first_q;
  assign item_o.last_col   = s1_last_col_q;
  assign item_o.row_number = s1_row_q;
  assign item_o.last_row   = s1_last_row_q;

endmodule

### src/mvrm_queue.sv
module mvrm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mvrm_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output mvrm_pkg::item_t item_o
);

  mvrm_pkg::item_t entries_q [mvrm_pkg::QUEUE_DEPTH];

  logic [mvrm_pkg::QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [mvrm_pkg::QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [mvrm_pkg::QUEUE_CNT_W-1:0] count_q, count_d;
  logic                             do_push, do_pop;

  assign full_o  = (count_q == mvrm_pkg::QUEUE_CNT_W'(mvrm_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign item_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + mvrm_pkg::QUEUE_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + mvrm_pkg::QUEUE_PTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + mvrm_pkg::QUEUE_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - mvrm_pkg::QUEUE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

### src/mvrm_back.sv
module mvrm_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  mvrm_pkg::item_t item_i,
  output logic            pop_o,
  mvrm_res_if.source      res_o
);

  localparam int unsigned DW = mvrm_pkg::DOT_W;
  localparam int unsigned VW = mvrm_pkg::VALUE_W;

  // multiply stage
  logic                   m_valid_q, m_valid_d;
  logic signed [DW-1:0]   m_prod_q;
  logic signed [VW-1:0]   m_value_q;
  logic                   m_first_q, m_last_col_q, m_last_row_q;
  logic [mvrm_pkg::ROW_W-1:0] m_row_q;

  // row state
  logic signed [DW-1:0]   acc_q, acc_d;
  logic signed [VW-1:0]   max_q, max_d;

  // result register
  logic                   out_valid_q, out_valid_d;
  logic signed [DW-1:0]   out_dot_q;
  logic signed [VW-1:0]   out_max_q;
  logic [mvrm_pkg::ROW_W-1:0] out_row_q;
  logic                   out_last_q;

  logic                   m_adv;
  logic [DW:0]            sum;
  logic signed [DW-1:0]   prod;

  // a row end waits only when the result register is still held
  assign m_adv = m_valid_q && (!m_last_col_q || !out_valid_q || res_o.ready);
  assign pop_o = valid_i && (!m_valid_q || m_adv);

  // full-width signed product of the two 32-bit operands
  assign prod = $signed(item_i.value) * $signed(item_i.vec);

  always_comb begin
    sum = {acc_q[DW-1], acc_q} + {m_prod_q[DW-1], m_prod_q};
    if (m_first_q) begin
      acc_d = m_prod_q;
      max_d = m_value_q;
    end else begin
      if (sum[DW] != sum[DW-1]) begin
        acc_d = sum[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      end else begin
        acc_d = sum[DW-1:0];
      end
      max_d = (m_value_q > max_q) ? m_value_q : max_q;
    end
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (m_adv) begin
      m_valid_d = 1'b0;
    end
    if (pop_o) begin
      m_valid_d = 1'b1;
    end
    out_valid_d = out_valid_q;
    if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (m_adv && m_last_col_q) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      max_q       <= '0;
    end else begin
      m_valid_q   <= m_valid_d;
      out_valid_q <= out_valid_d;
      if (m_adv) begin
        acc_q <= acc_d;
        max_q <= max_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      m_prod_q     <= prod;
      m_value_q    <= item_i.value;
      m_first_q    <= item_i.first_col;
      m_last_col_q <= item_i.last_col;
      m_row_q      <= item_i.row_number;
      m_last_row_q <= item_i.last_row;
    end
    if (m_adv && m_last_col_q) begin
      out_dot_q  <= acc_d;
      out_max_q  <= max_d;
      out_row_q  <= m_row_q;
      out_last_q <= m_last_row_q;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.dot_product = out_dot_q;
  assign res_o.row_max     = out_max_q;
  assign res_o.row_number  = out_row_q;
  assign res_o.last_row    = out_last_q;

endmodule

### src/matrix_vector_multiply_row_max_unit.sv
// a row's last element passes front register, queue, multiply stage, result register
// throughput: one request per cycle, vector loads and matrix elements alike, unless the queue is full
// the rate is set by the single 32x32 multiplier and the 64-bit saturating accumulator
// reset: positions, row state, handshake state cleared; col_count and row_count read 1
// the vector store is not cleared and holds no defined value until loaded
module matrix_vector_multiply_row_max_unit #(
  parameter int unsigned MAX_COLS    = 64,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  mvrm_req_if.sink                        req_i,
  mvrm_res_if.source                      res_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mvrm_pkg::PADDR_W-1:0]    paddr,
  input  logic [mvrm_pkg::APB_DATA_W-1:0] pwdata,
  output logic [mvrm_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  mvrm_pkg::cfg_t  cfg;
  mvrm_pkg::item_t front_item, queue_item;
  logic            push, q_full, q_valid, pop;

  mvrm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mvrm_front #(
    .MAX_COLS    (MAX_COLS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .req_i  (req_i),
    .full_i (q_full),
    .push_o (push),
    .item_o (front_item)
  );

  mvrm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (queue_item)
  );

  mvrm_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .item_i  (queue_item),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule

### tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mvrm_pkg::*;

  localparam int unsigned MAX_COLS     = 64;
  localparam int unsigned SETTLE_CYC   = 8;
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned RANDOM_ITEMS = 1700;

  typedef struct {
    logic signed [DOT_W-1:0]   dot_product;
    logic signed [VALUE_W-1:0] row_max;
    logic [ROW_W-1:0]          row_number;
    logic                      last_row;
  } row_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_W-1:0]    paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  mvrm_req_if req_bus ();
  mvrm_res_if res_bus ();

  matrix_vector_multiply_row_max_unit DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_bus),
    .res_o   (res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state
  logic [COL_CNT_W-1:0]      cfg_cols;
  logic [ROW_W-1:0]          cfg_rows;
  logic signed [VALUE_W-1:0] vec_mem [MAX_COLS];
  int unsigned               fill_idx;
  int unsigned               col_pos;
  int unsigned               row_pos;
  logic signed [DOT_W-1:0]   row_acc;
  logic signed [VALUE_W-1:0] row_peak;

  row_result_t pending_rows[$];
  int unsigned mismatch_count;
  int unsigned req_count;
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned quiet_cycles;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int unsigned active_cols();
    if (cfg_cols == 0) return 1;
    if (cfg_cols > MAX_COLS) return MAX_COLS;
    return cfg_cols;
  endfunction

  function automatic int unsigned active_rows();
    return (cfg_rows == 0) ? 1 : cfg_rows;
  endfunction

  function automatic logic signed [DOT_W-1:0] sat_sum(input logic signed [DOT_W-1:0] a,
                                                      input logic signed [DOT_W-1:0] b);
    logic signed [DOT_W:0] s;
    s = a + b;
    if (s[DOT_W] != s[DOT_W-1])
      return s[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}} : {1'b0, {(DOT_W-1){1'b1}}};
    return s[DOT_W-1:0];
  endfunction

  // apply one accepted request to vector or row sums, queue a row result at the last column
  task automatic update_row_sums(input req_type_e kind, input logic signed [VALUE_W-1:0] val);
    int unsigned cols;
    int unsigned rows;
    int unsigned col;
    int unsigned row;
    logic signed [DOT_W-1:0] lhs;
    logic signed [DOT_W-1:0] rhs;
    row_result_t res;
    cols = active_cols();
    rows = active_rows();
    if (kind == REQ_VECTOR) begin
      col = (fill_idx >= cols) ? cols - 1 : fill_idx;
      vec_mem[col] = val;
      fill_idx = (col + 1 >= cols) ? 0 : col + 1;
    end else begin
      col = (col_pos >= cols) ? cols - 1 : col_pos;
      lhs = val;
      rhs = vec_mem[col];
      if (col == 0) begin
        row_acc  = lhs * rhs;
        row_peak = val;
      end else begin
        row_acc = sat_sum(row_acc, lhs * rhs);
        if (val > row_peak) row_peak = val;
      end
      if (col + 1 < cols) begin
        col_pos = col + 1;
      end else begin
        row = (row_pos >= rows) ? rows - 1 : row_pos;
        res.dot_product = row_acc;
        res.row_max     = row_peak;
        res.row_number  = row[ROW_W-1:0];
        res.last_row    = (row + 1 >= rows);
        pending_rows.push_back(res);
        col_pos  = 0;
        row_pos  = res.last_row ? 0 : row + 1;
        row_acc  = '0;
        row_peak = '0;
      end
    end
  endtask

  // called and returns at a falling edge
  task automatic send_req(input req_type_e kind, input logic signed [VALUE_W-1:0] val);
    while ($urandom_range(99) < src_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_bus.valid    <= 1'b1;
    req_bus.req_type <= kind;
    req_bus.value    <= val;
    do @(posedge clk_i); while (!req_bus.ready);
    update_row_sums(kind, val);
    req_count++;
    @(negedge clk_i);
  endtask

  task automatic wait_drain();
    req_bus.valid <= 1'b0;
    while (pending_rows.size() != 0) @(negedge clk_i);
    // rows can still be in flight after the last expected one, e.g. partial rows
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_index_e idx, input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_COL_COUNT) cfg_cols = data[COL_CNT_W-1:0];
    else cfg_rows = data[ROW_W-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic signed [VALUE_W-1:0] rand_value();
    case ($urandom_range(7))
      0: return {1'b1, {(VALUE_W-1){1'b0}}};
      1: return {1'b0, {(VALUE_W-1){1'b1}}};
      2: return '0;
      3: return $signed(VALUE_W'($urandom_range(0, 2 ** 18))) - (2 ** 17);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [COL_CNT_W-1:0] pick_cols();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(1, 8);
    if (r < 90) return $urandom_range(9, MAX_COLS - 1);
    if (r < 94) return MAX_COLS;
    if (r < 97) return $urandom_range(MAX_COLS + 1, 127);
    return 0;
  endfunction

  function automatic logic [ROW_W-1:0] pick_rows();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 85) return $urandom_range(1, 6);
    if (r < 93) return $urandom_range(7, 300);
    if (r < 97) return 16'hFFFF;
    return 0;
  endfunction

  // every store entry gets written once, so no later read hits an unloaded entry
  task automatic test_vector_prefill();
    write_reg(REG_COL_COUNT, MAX_COLS);
    for (int i = 0; i < MAX_COLS; i++) send_req(REQ_VECTOR, rand_value());
  endtask

  task automatic test_saturation();
    wait_drain();
    write_reg(REG_COL_COUNT, 4);
    write_reg(REG_ROW_COUNT, 2);
    repeat (4) send_req(REQ_VECTOR, 32'sh8000_0000);
    // overflow upward, then pulled back into range by a negative product
    repeat (3) send_req(REQ_MATRIX, 32'sh8000_0000);
    send_req(REQ_MATRIX, 32'sh7FFF_FFFF);
    // overflow downward
    repeat (4) send_req(REQ_MATRIX, 32'sh7FFF_FFFF);
  endtask

  task automatic test_row_max_start();
    wait_drain();
    write_reg(REG_COL_COUNT, 3);
    write_reg(REG_ROW_COUNT, 1);
    // all negative: the peak must start from the first element, not from zero
    send_req(REQ_MATRIX, -32'sd5);
    send_req(REQ_MATRIX, -32'sd7);
    send_req(REQ_MATRIX, -32'sd1);
    send_req(REQ_MATRIX, 32'sh7FFF_FFFF);
    send_req(REQ_MATRIX, 32'sh8000_0000);
    send_req(REQ_MATRIX, 32'sd0);
  endtask

  task automatic test_overfill_interleave();
    wait_drain();
    repeat (5) send_req(REQ_VECTOR, rand_value());
    send_req(REQ_MATRIX, rand_value());
    send_req(REQ_VECTOR, rand_value());
    send_req(REQ_MATRIX, rand_value());
    send_req(REQ_MATRIX, rand_value());
  endtask

  task automatic test_register_clamp();
    wait_drain();
    write_reg(REG_COL_COUNT, 0);
    write_reg(REG_ROW_COUNT, 0);
    repeat (2) send_req(REQ_MATRIX, rand_value());
    wait_drain();
    write_reg(REG_COL_COUNT, 1);
    write_reg(REG_ROW_COUNT, 16'hFFFF);
    repeat (2) send_req(REQ_MATRIX, rand_value());
  endtask

  task automatic test_midstream_config();
    wait_drain();
    write_reg(REG_COL_COUNT, 5);
    write_reg(REG_ROW_COUNT, 3);
    repeat (3) send_req(REQ_VECTOR, rand_value());
    repeat (3) send_req(REQ_MATRIX, rand_value());
    wait_drain();
    // column, fill and row positions now sit past the new last index
    write_reg(REG_COL_COUNT, 2);
    write_reg(REG_ROW_COUNT, 1);
    send_req(REQ_VECTOR, rand_value());
    repeat (3) send_req(REQ_MATRIX, rand_value());
  endtask

  task automatic run_random_matrices();
    int unsigned cols;
    int unsigned n_elems;
    wait_drain();
    case ($urandom_range(3))
      0: write_reg(REG_COL_COUNT, pick_cols());
      1: write_reg(REG_ROW_COUNT, pick_rows());
      2: begin
        write_reg(REG_COL_COUNT, pick_cols());
        write_reg(REG_ROW_COUNT, pick_rows());
      end
      default: ;
    endcase
    cols = active_cols();
    if ($urandom_range(2) == 0)
      repeat (cols + $urandom_range(0, 1)) send_req(REQ_VECTOR, rand_value());
    n_elems = cols * ((cols > 8) ? $urandom_range(1, 2) : $urandom_range(1, 6));
    repeat (n_elems) begin
      if ($urandom_range(19) == 0) send_req(REQ_VECTOR, rand_value());
      send_req(REQ_MATRIX, rand_value());
    end
    // broken tail: may leave a row half done for the next settings
    if ($urandom_range(4) == 0)
      repeat ($urandom_range(1, cols)) send_req(REQ_MATRIX, rand_value());
  endtask

  task automatic test_random_traffic();
    int unsigned target;
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          src_idle_pct   = 35;
          sink_stall_pct = 69;
        end
        1: begin
          src_idle_pct   = 69;
          sink_stall_pct = 35;
        end
        default: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
      endcase
      target = req_count + RANDOM_ITEMS / 3;
      while (req_count < target) run_random_matrices();
    end
  endtask

  always @(negedge clk_i) res_bus.ready <= ($urandom_range(99) >= sink_stall_pct);

  always @(posedge clk_i) begin : row_check
    row_result_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (pending_rows.size() == 0) begin
        mismatch_count++;
        $error("row result with none pending: row_number %0d", res_bus.row_number);
      end else begin
        want = pending_rows.pop_front();
        if (res_bus.dot_product !== want.dot_product) begin
          mismatch_count++;
          $error("dot_product: expected %0d, got %0d", want.dot_product, res_bus.dot_product);
        end
        if (res_bus.row_max !== want.row_max) begin
          mismatch_count++;
          $error("row_max: expected %0d, got %0d", want.row_max, res_bus.row_max);
        end
        if (res_bus.row_number !== want.row_number) begin
          mismatch_count++;
          $error("row_number: expected %0d, got %0d", want.row_number, res_bus.row_number);
        end
        if (res_bus.last_row !== want.last_row) begin
          mismatch_count++;
          $error("last_row: expected %0b, got %0b", want.last_row, res_bus.last_row);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready)
        || (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    req_bus.valid    = 1'b0;
    req_bus.req_type = REQ_VECTOR;
    req_bus.value    = '0;
    res_bus.ready    = 1'b0;
    quiet_cycles     = 0;
    mismatch_count   = 0;
    req_count        = 0;
    src_idle_pct     = 0;
    sink_stall_pct   = 0;
    cfg_cols         = 1;
    cfg_rows         = 1;
    fill_idx         = 0;
    col_pos          = 0;
    row_pos          = 0;
    row_acc          = '0;
    row_peak         = '0;
    foreach (vec_mem[i]) vec_mem[i] = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_vector_prefill();
    test_saturation();
    test_row_max_start();
    test_overfill_interleave();
    test_register_clamp();
    test_midstream_config();
    test_random_traffic();
    wait_drain();

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
src/mvrm_pkg.sv
src/mvrm_req_if.sv
src/mvrm_res_if.sv
src/mvrm_cfg.sv
src/mvrm_front.sv
src/mvrm_queue.sv
src/mvrm_back.sv
src/matrix_vector_multiply_row_max_unit.sv
tb/tb_top.sv
